@@ sv/ata_pkg.sv @@
`timescale 1ns / 1ps
package ata_pkg;
   localparam int CordicSteps = 16;
   localparam int StepBits = 5;
   localparam int AccBits = 32;
   localparam int WideBits = 36;
   localparam int SqBits = 48;
   localparam int RootBits = 24;
   localparam int RootIters = 24;
   localparam logic [AccBits-1:0] AngleFull = 32'd589824000;

   typedef enum logic [1:0] {
      SEL_X = 2'd0,
      SEL_Y = 2'd1,
      SEL_Z = 2'd2
   } sel_type;

   typedef struct packed {
      logic    start_root;
      logic    start_cordic;
      logic    latch;
      sel_type sel;
   } cmd_type;

   typedef struct packed {
      logic root_done;
      logic cordic_done;
   } stat_type;

   function automatic logic [AccBits-1:0] atan_tab(input logic [StepBits-1:0] i);
      logic [AccBits-1:0] v;
      case (i)
         5'd0: v = 32'd294912000;
         5'd1: v = 32'd174096719;
         5'd2: v = 32'd91987925;
         5'd3: v = 32'd46694507;
         5'd4: v = 32'd23437865;
         5'd5: v = 32'd11730358;
         5'd6: v = 32'd5866610;
         5'd7: v = 32'd2933484;
         5'd8: v = 32'd1466764;
         5'd9: v = 32'd733385;
         5'd10: v = 32'd366693;
         5'd11: v = 32'd183346;
         5'd12: v = 32'd91673;
         5'd13: v = 32'd45837;
         5'd14: v = 32'd22918;
         5'd15: v = 32'd11459;
         5'd16: v = 32'd5730;
         5'd17: v = 32'd2865;
         5'd18: v = 32'd1432;
         5'd19: v = 32'd716;
         5'd20: v = 32'd358;
         5'd21: v = 32'd179;
         5'd22: v = 32'd90;
         5'd23: v = 32'd45;
         default: v = '0;
      endcase
      return v;
   endfunction
endpackage

@@ sv/ata_ctrl.sv @@
`timescale 1ns / 1ps
module ata_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   output logic              out_valid,
   input  logic              out_ready,
   output ata_pkg::cmd_type  cmd,
   input  ata_pkg::stat_type stat
);
   import ata_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE, S_ROOT, S_CORDIC, S_NEXT, S_OUT
   } state_type;

   state_type state_ff;
   sel_type   sel_ff;
   logic      out_valid_ff;

   assign in_ready  = (state_ff == S_IDLE) && !out_valid_ff;
   assign out_valid = out_valid_ff;

   always_comb begin
      cmd.latch        = in_valid && in_ready;
      cmd.start_root   = (state_ff == S_NEXT);
      cmd.start_cordic = (state_ff == S_ROOT) && stat.root_done;
      cmd.sel          = sel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sel_ff       <= SEL_X;
         out_valid_ff <= 1'b0;
      end else begin
         if (out_valid_ff && out_ready) out_valid_ff <= 1'b0;
         case (state_ff)
            S_IDLE: if (in_valid && in_ready) begin
               sel_ff   <= SEL_X;
               state_ff <= S_NEXT;
            end
            S_NEXT: state_ff <= S_ROOT;
            S_ROOT: if (stat.root_done) state_ff <= S_CORDIC;
            S_CORDIC: if (stat.cordic_done) begin
               case (sel_ff)
                  SEL_X: begin sel_ff <= SEL_Y; state_ff <= S_NEXT; end
                  SEL_Y: begin sel_ff <= SEL_Z; state_ff <= S_NEXT; end
                  default: state_ff <= S_OUT;
               endcase
            end
            S_OUT: if (!out_valid_ff) begin
               out_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sv/ata_dp.sv @@
`timescale 1ns / 1ps
module ata_dp (
   input  logic                clock,
   input  logic                reset,
   input  ata_pkg::cmd_type    cmd,
   output ata_pkg::stat_type   stat,
   input  logic [1:0]          status_flags,
   input  logic signed [15:0]  accel_x,
   input  logic signed [15:0]  accel_y,
   input  logic signed [15:0]  accel_z,
   output logic signed [14:0]  angle_x,
   output logic signed [14:0]  angle_y,
   output logic signed [14:0]  angle_z
);
   import ata_pkg::*;

   logic signed [15:0] held_x_ff, held_y_ff, held_z_ff;
   logic [15:0] mag_x, mag_y, mag_z, mag_a, mag_b, mag_n;
   logic neg_n;

   // root unit
   logic [SqBits-1:0]   rem_ff, rad_ff;
   logic [RootBits-1:0] root_ff;
   logic [4:0]          rcnt_ff;
   logic                rbusy_ff;
   logic [SqBits-1:0]   sq_sum;
   logic [RootBits+1:0] trial;
   logic [SqBits-1:0]   rem_sh;

   // cordic unit
   logic signed [WideBits-1:0] cx_ff, cy_ff;
   logic signed [AccBits:0]    acc_ff;
   logic [StepBits-1:0]        ccnt_ff;
   logic                       cbusy_ff, cdone_ff;
   logic                       zero_num_ff, zero_den_ff;
   logic signed [WideBits-1:0] dx, dy;
   logic signed [AccBits:0]    tab_s, acc_c;
   logic [14:0]                mag_out;
   logic signed [14:0]         ang_x_ff, ang_y_ff, ang_z_ff;
   logic signed [14:0]         ang_s;
   logic [WideBits-1:0]        num_w, den_w;

   always_ff @(posedge clock) begin
      if (reset) begin
         held_x_ff <= '0;
         held_y_ff <= '0;
         held_z_ff <= '0;
      end else if (cmd.latch && (status_flags != 2'b00)) begin
         held_x_ff <= accel_x;
         held_y_ff <= accel_y;
         held_z_ff <= accel_z;
      end
   end

   assign mag_x = held_x_ff[15] ? 16'(-held_x_ff) : 16'(held_x_ff);
   assign mag_y = held_y_ff[15] ? 16'(-held_y_ff) : 16'(held_y_ff);
   assign mag_z = held_z_ff[15] ? 16'(-held_z_ff) : 16'(held_z_ff);

   always_comb begin
      case (cmd.sel)
         SEL_X: begin mag_a = mag_y; mag_b = mag_z; mag_n = mag_x; neg_n = held_x_ff[15]; end
         SEL_Y: begin mag_a = mag_x; mag_b = mag_z; mag_n = mag_y; neg_n = held_y_ff[15]; end
         default: begin mag_a = mag_x; mag_b = mag_y; mag_n = mag_z; neg_n = held_z_ff[15]; end
      endcase
   end

   assign sq_sum = ({16'd0, mag_a} * {16'd0, mag_a} + {16'd0, mag_b} * {16'd0, mag_b}) << 16;

   // restoring root, two radicand bits a cycle
   assign rem_sh = {rem_ff[SqBits-3:0], rad_ff[SqBits-1:SqBits-2]};
   assign trial  = {root_ff, 2'b01};

   always_ff @(posedge clock) begin
      if (reset) begin
         rbusy_ff <= 1'b0;
         rcnt_ff  <= '0;
      end else if (cmd.start_root) begin
         rbusy_ff <= 1'b1;
         rcnt_ff  <= '0;
         rem_ff   <= '0;
         root_ff  <= '0;
         rad_ff   <= sq_sum;
      end else if (rbusy_ff) begin
         rad_ff <= {rad_ff[SqBits-3:0], 2'b00};
         if (rem_sh >= SqBits'(trial)) begin
            rem_ff  <= rem_sh - SqBits'(trial);
            root_ff <= {root_ff[RootBits-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[RootBits-2:0], 1'b0};
         end
         rcnt_ff <= rcnt_ff + 5'd1;
         if (rcnt_ff == 5'(RootIters - 1)) rbusy_ff <= 1'b0;
      end
   end

   assign stat.root_done = rbusy_ff && (rcnt_ff == 5'(RootIters - 1));

   // start_cordic fires with the last root step; the load waits on start_d_ff, so root_ff is final when it is used
   assign num_w = (cmd.sel == SEL_Z) ? WideBits'(root_ff) : WideBits'({mag_n, 8'd0});
   assign den_w = (cmd.sel == SEL_Z) ? WideBits'({mag_n, 8'd0}) : WideBits'(root_ff);

   assign dx    = cy_ff >>> ccnt_ff;
   assign dy    = cx_ff >>> ccnt_ff;
   assign tab_s = (AccBits+1)'(atan_tab(ccnt_ff));

   always_comb begin
      acc_c = acc_ff;
      if (acc_ff < 0) acc_c = '0;
      if (acc_ff > $signed({1'b0, AngleFull})) acc_c = $signed({1'b0, AngleFull});
      if (zero_num_ff) acc_c = '0;
      else if (zero_den_ff) acc_c = $signed({1'b0, AngleFull});
   end
   assign mag_out = 15'((acc_c + 33'sd32768) >>> 16);
   assign ang_s   = neg_n ? 15'(-mag_out) : mag_out;

   logic start_d_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         cbusy_ff   <= 1'b0;
         cdone_ff   <= 1'b0;
         start_d_ff <= 1'b0;
      end else begin
         start_d_ff <= cmd.start_cordic;
         cdone_ff   <= cbusy_ff && !start_d_ff && (ccnt_ff == StepBits'(CordicSteps - 1));
         if (start_d_ff) begin
            cx_ff       <= $signed(den_w);
            cy_ff       <= $signed(num_w);
            acc_ff      <= '0;
            ccnt_ff     <= '0;
            zero_num_ff <= (num_w == '0);
            zero_den_ff <= (den_w == '0);
            cbusy_ff    <= 1'b1;
         end else if (cbusy_ff) begin
            if (!cy_ff[WideBits-1]) begin
               cx_ff  <= cx_ff + dx;
               cy_ff  <= cy_ff - dy;
               acc_ff <= acc_ff + tab_s;
            end else begin
               cx_ff  <= cx_ff - dx;
               cy_ff  <= cy_ff + dy;
               acc_ff <= acc_ff - tab_s;
            end
            ccnt_ff <= ccnt_ff + 5'd1;
            if (ccnt_ff == StepBits'(CordicSteps - 1)) cbusy_ff <= 1'b0;
         end
         if (cdone_ff) begin
            case (cmd.sel)
               SEL_X: ang_x_ff <= ang_s;
               SEL_Y: ang_y_ff <= ang_s;
               default: ang_z_ff <= ang_s;
            endcase
         end
      end
   end

   assign stat.cordic_done = cdone_ff;
   assign angle_x = ang_x_ff;
   assign angle_y = ang_y_ff;
   assign angle_z = ang_z_ff;
endmodule

@@ sv/accel_tilt_angles_unit.sv @@
`timescale 1ns / 1ps
// Tilt angle unit: turns a three-axis accelerometer sample into three angles
// in hundredths of a degree (-9000..9000).
// Input channel req_: one beat carries status_flags and the x, y, z sample.
// If any status bit is set the sample is latched, else the held sample is used.
// Result channel rsp_: one beat per input beat with angle_x, angle_y, angle_z.
// The block works on one beat at a time: with a ready receiver it takes a new
// beat only after the result of the last one is out. Each angle takes a setup
// state, a 24-step radix-4 square root and a 16-step CORDIC (load, one
// iteration a cycle, write back), run three times.
// req_tready is high only while the unit is idle and the result register is
// empty. A stalled receiver holds the result and the unit takes no new beat
// until it is taken. Reset clears the held sample to zero and empties the
// result register.
module accel_tilt_angles_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // status_flags [1:0]
   input  logic [47:0] req_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // angle_x [14:0], angle_y [29:15], angle_z [44:30]
);
   import ata_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic signed [14:0] ax, ay, az;

   ata_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .cmd(cmd), .stat(stat)
   );

   ata_dp u_dp (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .status_flags(req_tuser),
      .accel_x(req_tdata[15:0]), .accel_y(req_tdata[31:16]), .accel_z(req_tdata[47:32]),
      .angle_x(ax), .angle_y(ay), .angle_z(az)
   );

   assign rsp_tdata = {3'b000, az, ay, ax};

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("input taken while result pending");
   a_cmd_excl: assert property (@(posedge clock) disable iff (reset)
      !(cmd.start_root && cmd.start_cordic)) else $error("root and cordic start together");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(ax) <= 15'sd9000 && $signed(ax) >= -15'sd9000))
      else $error("angle_x out of range");
`endif
endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
module tb_top;
   import ata_pkg::*;

   localparam int Period = 10;
   localparam int StallLimit = 5000;
   localparam int RandomBeats = 1300;
   localparam logic [1:0] AccelReady = 2'b01;
   localparam logic [1:0] GyroReady = 2'b10;
   localparam logic [1:0] NoneReady = 2'b00;

   typedef struct {
      logic signed [14:0] ang_x;
      logic signed [14:0] ang_y;
      logic signed [14:0] ang_z;
   } tilt_type;

   // Predict tilt angles from a held sample and keep them in arrival order.
   class tilt_scoreboard;
      logic signed [15:0] held_x, held_y, held_z;
      tilt_type pending[$];
      int errors;

      function new();
         held_x = '0;
         held_y = '0;
         held_z = '0;
         errors = 0;
      endfunction

      function longint unsigned root_sum(longint a, longint b);
         longint unsigned v, res, bitv;
         v = longint'(a * a + b * b) << 16;
         res = 0;
         bitv = 64'd1 << 62;
         while (bitv > v) bitv >>= 2;
         while (bitv != 0) begin
            if (v >= res + bitv) begin
               v -= res + bitv;
               res = (res >> 1) + bitv;
            end else begin
               res >>= 1;
            end
            bitv >>= 2;
         end
         return res;
      endfunction

      function int quadrant_angle(longint num, longint den);
         longint xs, ys, acc, dx, dy;
         xs = den;
         ys = num;
         acc = 0;
         if (num == 0) return 0;
         if (den == 0) return 9000;
         for (int i = 0; i < CordicSteps && i < 24; i++) begin
            dx = ys >>> i;
            dy = xs >>> i;
            if (ys >= 0) begin
               xs += dx;
               ys -= dy;
               acc += longint'(atan_tab(i[4:0]));
            end else begin
               xs -= dx;
               ys += dy;
               acc -= longint'(atan_tab(i[4:0]));
            end
         end
         if (acc < 0) acc = 0;
         if (acc > longint'(AngleFull)) acc = longint'(AngleFull);
         return int'((acc + 32768) >>> 16);
      endfunction

      function void note_sample(logic [1:0] flags, logic [47:0] sample);
         longint ax, ay, az, mx, my, mz;
         int ang;
         tilt_type t;
         if (flags != NoneReady) begin
            held_x = sample[15:0];
            held_y = sample[31:16];
            held_z = sample[47:32];
         end
         ax = held_x;
         ay = held_y;
         az = held_z;
         mx = (ax < 0 ? -ax : ax) << 8;
         my = (ay < 0 ? -ay : ay) << 8;
         mz = (az < 0 ? -az : az) << 8;
         ang = quadrant_angle(mx, root_sum(ay, az));
         t.ang_x = 15'(ax < 0 ? -ang : ang);
         ang = quadrant_angle(my, root_sum(ax, az));
         t.ang_y = 15'(ay < 0 ? -ang : ang);
         ang = quadrant_angle(root_sum(ax, ay), mz);
         t.ang_z = 15'(az < 0 ? -ang : ang);
         pending.push_back(t);
      endfunction

      function void check_angles(logic [47:0] data);
         tilt_type t;
         if (pending.size() == 0) begin
            $error("unexpected result beat %h", data);
            errors++;
            return;
         end
         t = pending.pop_front();
         if (data[14:0] !== t.ang_x) begin
            $error("angle_x: expected %0d, got %0d", t.ang_x, $signed(data[14:0]));
            errors++;
         end
         if (data[29:15] !== t.ang_y) begin
            $error("angle_y: expected %0d, got %0d", t.ang_y, $signed(data[29:15]));
            errors++;
         end
         if (data[44:30] !== t.ang_z) begin
            $error("angle_z: expected %0d, got %0d", t.ang_z, $signed(data[44:30]));
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [1:0] req_tuser = '0;
   logic [47:0] req_tdata = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [47:0] rsp_tdata;
   int idle_cycles = 0;
   tilt_scoreboard angle_board;

   always #(Period / 2) clock = ~clock;

   accel_tilt_angles_unit i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tuser(req_tuser), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   initial angle_board = new();

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) angle_board.note_sample(req_tuser, req_tdata);
         if (rsp_tvalid && rsp_tready) angle_board.check_angles(rsp_tdata);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= StallLimit) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   // Leave tvalid high after a beat; the next call drops it only for a gap.
   task automatic send_sample(logic [1:0] flags, logic signed [15:0] sx,
                              logic signed [15:0] sy, logic signed [15:0] sz,
                              bit quiet);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 13);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= flags;
      req_tdata <= {sz, sy, sx};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   function automatic logic [15:0] pick_axis();
      case ($urandom_range(0, 5))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'(int'($urandom_range(0, 20)) - 10);
         3: return 16'h0000;
         default: return 16'($urandom);
      endcase
   endfunction

   // Receiver: random stalls, now and then none before a beat.
   initial begin
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 13);
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   initial begin
      logic [1:0] flags;
      bit quiet;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Edge cases: zero sample, zero divisors, extremes, held sample reuse.
      send_sample(NoneReady, 16'sd5, 16'sd5, 16'sd5, 0);
      send_sample(AccelReady, 16'sd0, 16'sd0, 16'sd0, 0);
      send_sample(GyroReady, 16'sd100, 16'sd0, 16'sd0, 0);
      send_sample(AccelReady, -16'sd100, 16'sd0, 16'sd0, 0);
      send_sample(AccelReady, 16'sd0, 16'sd0, -16'sd7, 0);
      send_sample(AccelReady, 16'sd0, 16'sd0, 16'sd7, 0);
      send_sample(2'b11, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 0);
      send_sample(AccelReady, 16'sh8000, 16'sh8000, 16'sh8000, 0);
      send_sample(NoneReady, 16'sd1, 16'sd2, 16'sd3, 0);
      send_sample(AccelReady, 16'sh8000, 16'sh7FFF, 16'sd0, 0);
      send_sample(AccelReady, 16'sd0, 16'sh8000, 16'sh7FFF, 0);
      send_sample(AccelReady, 16'sd1, -16'sd1, 16'sd1, 0);
      send_sample(GyroReady, -16'sd1, 16'sd0, 16'sd16384, 0);
      send_sample(AccelReady, 16'sd3, 16'sd4, 16'sd0, 0);
      req_tvalid <= 1'b0;

      // Hold off until every result is in.
      while (angle_board.pending.size() != 0) @(negedge clock);

      for (int n = 0; n < RandomBeats; n++) begin
         flags = ($urandom_range(0, 4) == 0) ? NoneReady : 2'($urandom_range(1, 3));
         quiet = (n % 200) < 30;
         send_sample(flags, pick_axis(), pick_axis(), pick_axis(), quiet);
      end
      req_tvalid <= 1'b0;

      while (angle_board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (angle_board.errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end
endmodule

@@ files.f @@
sv/ata_pkg.sv
sv/ata_ctrl.sv
sv/ata_dp.sv
sv/accel_tilt_angles_unit.sv
tb/tb_top.sv
